// ===== rtl/core/thumb_instruction_cycle_count_unit_defines.svh =====
// assertion macros for the thumb instruction cycle count unit
// expects i_clk and i_rst_n in the scope of each use
`ifndef THUMB_INSTRUCTION_CYCLE_COUNT_UNIT_DEFINES_SVH
`define THUMB_INSTRUCTION_CYCLE_COUNT_UNIT_DEFINES_SVH
`ifndef SYNTH
// checked outside reset
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TCC_ASSERT(lbl, prop, msg)
`define TCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/tcc_pkg.sv =====
// shared types, constants and helper functions of the cycle count unit
// no dependencies
package tcc_pkg;

    typedef enum logic [1:0] {
        CLS_FIXED,
        CLS_MULTI,
        CLS_DIV
    } t_class;

    localparam logic [4:0] CYC_ONE   = 5'd1;
    localparam logic [4:0] CYC_TWO   = 5'd2;
    localparam logic [4:0] CYC_THREE = 5'd3;
    localparam logic [4:0] CYC_FOUR  = 5'd4;
    localparam logic [4:0] DIV_CAP   = 5'd12;

    // decoded item after the first stage
    typedef struct packed {
        t_class      cls;
        logic [4:0]  fixed;
        logic [15:0] list;
        logic [1:0]  extra;
        logic [31:0] num;
        logic [31:0] den;
    } t_dec;

    // counted item after the second stage
    typedef struct packed {
        t_class      cls;
        logic [4:0]  fixed;
        logic [4:0]  multi;
        logic        div_short;
        logic [5:0]  clz_num;
        logic [5:0]  clz_den;
    } t_cnt;

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 16; i++) begin
            n = n + {4'd0, v[i]};
        end
        return n;
    endfunction

    // leading zero count, 32 for zero
    function automatic logic [5:0] clz32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    // d / 3 for d below 32, by reciprocal multiply
    function automatic logic [3:0] quot3(input logic [4:0] d);
        logic [9:0] p;
        p = {5'd0, d} * 10'd11;
        return p[8:5];
    endfunction

endpackage

// ===== rtl/core/tcc_if.sv =====
// valid/ready channel interfaces of the cycle count unit
// depends on nothing
interface tcc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_half;
    logic [15:0] second_half;
    logic        is_wide;
    logic        executed;
    logic        branch_taken;
    logic [31:0] dividend_value;
    logic [31:0] divisor_value;

    modport source (
        output valid, first_half, second_half, is_wide, executed, branch_taken,
               dividend_value, divisor_value,
        input  ready
    );
    modport sink (
        input  valid, first_half, second_half, is_wide, executed, branch_taken,
               dividend_value, divisor_value,
        output ready
    );
endinterface

interface tcc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] exec_cycles;

    modport source (output valid, exec_cycles, input ready);
    modport sink (input valid, exec_cycles, output ready);
endinterface

// ===== rtl/core/thumb_instruction_cycle_count_unit.sv =====
// thumb instruction cycle count unit, top level
// an accepted item is registered in stage 1, then in stage 2, then in the stage 3 output register
// throughput: one item per cycle; every stage holds an item and moves when the next frees up
// a stalled output holds its result; intake stops only once the stages behind it are full
// reset: synchronous active-low reset clears all stage valid bits, payload is not reset
module thumb_instruction_cycle_count_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcc_in_if.sink    i_in,
    tcc_out_if.source o_out
);

`include "thumb_instruction_cycle_count_unit_defines.svh"

    // stage 1 -> stage 2
    logic          w_v1;
    logic          w_rdy1;
    tcc_pkg::t_dec w_d1;
    // stage 2 -> stage 3
    logic          w_v2;
    logic          w_rdy2;
    tcc_pkg::t_cnt w_d2;
    // stage 3 is the output register
    logic          w_v3;
    logic          w_rdy3;
    logic [4:0]    w_cycles;

    // classify the instruction and take divide operand magnitudes
    tcc_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in.valid),
        .i_first_half     (i_in.first_half),
        .i_second_half    (i_in.second_half),
        .i_is_wide        (i_in.is_wide),
        .i_executed       (i_in.executed),
        .i_branch_taken   (i_in.branch_taken),
        .i_dividend_value (i_in.dividend_value),
        .i_divisor_value  (i_in.divisor_value),
        .o_ready          (i_in.ready),
        .i_ready          (w_rdy2),
        .o_valid          (w_v1),
        .o_data           (w_d1)
    );

    // count transferred registers and leading zeros of the divide operands
    tcc_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .i_data  (w_d1),
        .o_ready (w_rdy2),
        .i_ready (w_rdy3),
        .o_valid (w_v2),
        .o_data  (w_d2)
    );

    // divide estimate and final pick
    tcc_result u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v2),
        .i_data   (w_d2),
        .o_ready  (w_rdy3),
        .i_ready  (o_out.ready),
        .o_valid  (w_v3),
        .o_cycles (w_cycles)
    );

    assign w_rdy1            = i_in.ready;
    assign o_out.valid       = w_v3;
    assign o_out.exec_cycles = w_cycles;

    // reset empties the whole pipe
    `TCC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!w_v1 && !w_v2 && !w_v3), "pipe not empty after reset")
    // an accepted item lands in stage 1
    `TCC_ASSERT(a_accept_lands, (i_in.valid && w_rdy1) |=> w_v1, "accepted item lost at stage 1")
    // a full stage 3 that is not drained blocks stage 2
    `TCC_ASSERT(a_stall_holds, (w_v3 && !o_out.ready) |-> !w_rdy3, "stage 3 overwritten while stalled")
    // results stay within the cycle range
    `TCC_ASSERT(a_range, w_v3 |-> (w_cycles >= 5'd1 && w_cycles <= 5'd19), "cycle count out of range")

endmodule

// ===== rtl/core/tcc_decode.sv =====
// stage 1: instruction classification and divide operand magnitudes
// depends on tcc_pkg
module tcc_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [15:0]   i_first_half,
    input  logic [15:0]   i_second_half,
    input  logic          i_is_wide,
    input  logic          i_executed,
    input  logic          i_branch_taken,
    input  logic [31:0]   i_dividend_value,
    input  logic [31:0]   i_divisor_value,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output tcc_pkg::t_dec o_data
);

    localparam logic [15:0] OP_TBB    = 16'he8d0;
    localparam logic [15:0] OP_SDIV   = 16'hfb90;
    localparam logic [15:0] OP_UDIV   = 16'hfbb0;
    localparam logic [15:0] OP_STM_W  = 16'he880;
    localparam logic [15:0] OP_LDM_W  = 16'he890;
    localparam logic [15:0] OP_STMDB  = 16'he900;
    localparam logic [15:0] OP_DUAL   = 16'he840;
    localparam logic [15:0] OP_LDREX  = 16'he850;
    localparam logic [15:0] OP_STREXB = 16'he8c0;
    localparam logic [15:0] OP_PUSH   = 16'hb400;
    localparam logic [15:0] OP_POP    = 16'hbc00;
    localparam logic [15:0] OP_MUL_N  = 16'h4340;
    localparam logic [15:0] OP_CBZ    = 16'hb100;
    localparam logic [15:0] OP_LDRLIT = 16'h4800;

    logic          r_valid;
    tcc_pkg::t_dec r_data;
    tcc_pkg::t_dec n_data;

    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] op;
    logic [15:0] bf;
    logic        tbb, br_n, br_w, ldm_w, dual_w, div_w, excl_w, mul;
    logic        mem_n, ld_n;
    logic        sgn;

    assign a  = i_first_half;
    assign b  = i_second_half;
    assign op = a & 16'hfff0;
    assign bf = b & 16'hd000;

    always_comb begin
        tbb  = (op == OP_TBB) && ((b & 16'hffe0) == 16'hf000);
        br_n = ((a[15:12] == 4'hd) && (a[11:8] < 4'd14)) || (a[15:11] == 5'b11100) ||
               (a[15:8] == 8'h47) || ((a & 16'hf500) == OP_CBZ);
        br_w = ((a[15:11] == 5'b11110) &&
                ((bf inside {16'h9000, 16'hd000, 16'hc000}) ||
                 ((bf == 16'h8000) && (a[9:6] < 4'd14)))) || tbb;
        ldm_w = (((a & 16'hffd0) == OP_STM_W) || ((a & 16'hffd0) == OP_LDM_W) ||
                 ((a & 16'hffc0) == OP_STMDB)) && (b != 16'd0);
        dual_w = ((a & 16'hfe40) == OP_DUAL) && (a[8] || a[5]);
        div_w  = ((op == OP_UDIV) || (op == OP_SDIV)) && (b[7:4] == 4'hf);
        excl_w = ((op == OP_LDREX) && (b[11:8] == 4'hf)) ||
                 ((op == OP_DUAL) && !b[11]) ||
                 (((op == OP_TBB) || (op == OP_STREXB)) && (b[11:8] == 4'hf));
        mul    = i_is_wide ? (a[15:8] == 8'hfb) : ((a & 16'hffc0) == OP_MUL_N);
        // narrow single load/store
        mem_n = 1'b1;
        ld_n  = 1'b0;
        if ((a & 16'hf800) == OP_LDRLIT) begin
            ld_n = 1'b1;
        end else if (a[15:12] == 4'h5) begin
            ld_n = (a[11:9] >= 3'd3);
        end else if ((a[15:13] == 3'b011) || (a[15:12] == 4'h8) || (a[15:12] == 4'h9)) begin
            ld_n = a[11];
        end else begin
            mem_n = 1'b0;
        end
    end

    always_comb begin
        sgn          = !a[5];
        n_data.cls   = tcc_pkg::CLS_FIXED;
        n_data.fixed = tcc_pkg::CYC_ONE;
        n_data.list  = 16'd0;
        n_data.extra = 2'd0;
        n_data.num   = (sgn && i_dividend_value[31]) ? (~i_dividend_value + 32'd1)
                                                     : i_dividend_value;
        n_data.den   = (sgn && i_divisor_value[31]) ? (~i_divisor_value + 32'd1)
                                                    : i_divisor_value;
        if (!i_executed) begin
            n_data.fixed = tcc_pkg::CYC_ONE;
        end else if (i_is_wide && tbb) begin
            n_data.fixed = tcc_pkg::CYC_FOUR;
        end else if (i_is_wide ? br_w : br_n) begin
            n_data.fixed = i_branch_taken ? tcc_pkg::CYC_THREE : tcc_pkg::CYC_ONE;
        end else if (i_is_wide && ldm_w) begin
            n_data.cls   = tcc_pkg::CLS_MULTI;
            n_data.list  = b;
            n_data.extra = (a[4] && b[15]) ? 2'd2 : 2'd0;
        end else if (i_is_wide && dual_w) begin
            n_data.fixed = tcc_pkg::CYC_THREE;
        end else if (!i_is_wide && (a[15:12] == 4'hc)) begin
            n_data.cls  = tcc_pkg::CLS_MULTI;
            n_data.list = {8'd0, a[7:0]};
        end else if (!i_is_wide && ((a & 16'hfe00) == OP_PUSH)) begin
            n_data.cls   = tcc_pkg::CLS_MULTI;
            n_data.list  = {8'd0, a[7:0]};
            n_data.extra = {1'b0, a[8]};
        end else if (!i_is_wide && ((a & 16'hfe00) == OP_POP)) begin
            // pc pop costs the transfer plus a pipeline refill
            n_data.cls   = tcc_pkg::CLS_MULTI;
            n_data.list  = {8'd0, a[7:0]};
            n_data.extra = a[8] ? 2'd3 : 2'd0;
        end else if (i_is_wide && div_w) begin
            n_data.cls = tcc_pkg::CLS_DIV;
        end else if (i_is_wide && excl_w) begin
            n_data.fixed = tcc_pkg::CYC_TWO;
        end else if (mul) begin
            n_data.fixed = tcc_pkg::CYC_ONE;
        end else if (i_is_wide) begin
            if (a[15:8] inside {8'hf8, 8'hf9, 8'he8}) begin
                if (a[4] && (b[15:12] == 4'hf)) begin
                    n_data.fixed = tcc_pkg::CYC_FOUR;
                end else begin
                    n_data.fixed = a[4] ? tcc_pkg::CYC_TWO : tcc_pkg::CYC_ONE;
                end
            end
        end else if (mem_n) begin
            n_data.fixed = ld_n ? tcc_pkg::CYC_TWO : tcc_pkg::CYC_ONE;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/tcc_count.sv =====
// stage 2: register list popcount, divide operand clz and compare
// depends on tcc_pkg
module tcc_count (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tcc_pkg::t_dec i_data,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output tcc_pkg::t_cnt o_data
);

    logic          r_valid;
    tcc_pkg::t_cnt r_data;
    tcc_pkg::t_cnt n_data;

    always_comb begin
        n_data.cls       = i_data.cls;
        n_data.fixed     = i_data.fixed;
        n_data.multi     = tcc_pkg::CYC_ONE + tcc_pkg::popcount16(i_data.list) +
                           {3'd0, i_data.extra};
        n_data.div_short = (i_data.den == 32'd0) || (i_data.num < i_data.den);
        n_data.clz_num   = tcc_pkg::clz32(i_data.num);
        n_data.clz_den   = tcc_pkg::clz32(i_data.den);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/tcc_result.sv =====
// stage 3: divide cycle estimate and final selection into the output register
// depends on tcc_pkg
module tcc_result (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tcc_pkg::t_cnt i_data,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [4:0]    o_cycles
);

    logic       r_valid;
    logic [4:0] r_cycles;
    logic [4:0] n_cycles;
    logic [5:0] diff;
    logic [4:0] div_cyc;

    always_comb begin
        // only used when dividend is at least divisor, so diff stays in 0..31
        diff    = i_data.clz_den - i_data.clz_num;
        div_cyc = tcc_pkg::CYC_TWO + {1'b0, tcc_pkg::quot3(diff[4:0])};
        if (div_cyc > tcc_pkg::DIV_CAP) begin
            div_cyc = tcc_pkg::DIV_CAP;
        end
        case (i_data.cls)
            tcc_pkg::CLS_FIXED: n_cycles = i_data.fixed;
            tcc_pkg::CLS_MULTI: n_cycles = i_data.multi;
            tcc_pkg::CLS_DIV:   n_cycles = i_data.div_short ? tcc_pkg::CYC_TWO : div_cyc;
            default:            n_cycles = tcc_pkg::CYC_ONE;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cycles <= n_cycles;
        end
    end

    assign o_valid  = r_valid;
    assign o_cycles = r_cycles;

endmodule
